FILE: design/wavs_pkg.sv
// Shared types and constants for the WAV stream to PCM16 unit.
// No dependencies.
package wavs_pkg;

  localparam logic [31:0] RIFF_ID = 32'h52494646;
  localparam logic [31:0] WAVE_ID = 32'h57415645;
  localparam logic [31:0] FMT_ID  = 32'h666D7420;
  localparam logic [31:0] DATA_ID = 32'h64617461;
  localparam logic [5:0]  MIN_FILE_BYTES = 6'd44;
  localparam logic [15:0] FMT_FLOAT = 16'd3;

  localparam logic [1:0] ST_FRAME    = 2'd0;
  localparam logic [1:0] ST_ACCEPTED = 2'd1;
  localparam logic [1:0] ST_BAD_HDR  = 2'd2;
  localparam logic [1:0] ST_UNUSABLE = 2'd3;

  localparam int QDEPTH = 4;

  // Work handed from the parser to the converter, one per accepted byte.
  typedef struct packed {
    logic        frame_v;
    logic        final_v;
    logic [1:0]  status;
    logic        frame_last;
    logic [31:0] raw_first;
    logic [31:0] raw_second;
    logic [15:0] fmt_code;
    logic [15:0] bits;
    logic        chan_one;
    logic [31:0] rate;
    logic [31:0] total;
  } wavs_job_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [15:0] pcm_first;
    logic signed [15:0] pcm_second;
    logic signed [23:0] mono_level;
    logic [1:0]         channels_out;
    logic [31:0]        rate_hz;
    logic [31:0]        frame_total;
    logic               result_last;
  } wavs_result_t;

  typedef struct packed {
    logic         frame_v;
    logic         final_v;
    wavs_result_t frame_res;
    wavs_result_t final_res;
  } wavs_push_t;

  typedef struct packed {
    logic [2:0] count;
    logic       empty;
  } wavs_qstat_t;

endpackage

FILE: design/wavs_if.sv
// Stream channel interfaces: byte input and result output.
// Depends on nothing.
interface wavs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;
  modport source(output valid, data_byte, end_of_file, input ready);
  modport sink(input valid, data_byte, end_of_file, output ready);
endinterface

interface wavs_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [15:0] pcm_first;
  logic signed [15:0] pcm_second;
  logic signed [23:0] mono_level;
  logic [1:0]         channels_out;
  logic [31:0]        rate_hz;
  logic [31:0]        frame_total;
  logic               result_last;
  modport source(output valid, status, pcm_first, pcm_second, mono_level, channels_out,
                 rate_hz, frame_total, result_last, input ready);
  modport sink(input valid, status, pcm_first, pcm_second, mono_level, channels_out,
               rate_hz, frame_total, result_last, output ready);
endinterface

FILE: design/wavs_parser.sv
// RIFF/WAVE chunk walker and frame assembler; emits one job per byte.
// Depends on wavs_pkg.
module wavs_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  logic [7:0]          data_byte,
  input  logic                eof,
  output wavs_pkg::wavs_job_t job_r
);

  typedef enum logic [2:0] {
    PH_HEADER, PH_CHUNK_HEAD, PH_FMT, PH_DATA, PH_SKIP, PH_PAD, PH_BAD
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [4:0]  pos_r, pos_nxt;
  logic [31:0] id_r, id_nxt;
  logic [31:0] remain_r, remain_nxt;
  logic        pad_r, pad_nxt;
  logic [15:0] fmt_r, fmt_nxt;
  logic [15:0] chan_r, chan_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [15:0] align_r, align_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic [31:0] fbc_r, fbc_nxt;
  logic [31:0] first_r, first_nxt;
  logic [31:0] second_r, second_nxt;
  logic [31:0] frames_r, frames_nxt;
  logic [5:0]  len_r, len_nxt;
  logic [31:0] fsize_r, fsize_nxt;
  wavs_pkg::wavs_job_t job_nxt;

  logic [28:0] fprod;
  logic [15:0] ssz;
  logic [31:0] qs;
  logic [31:0] raw1, raw2;

  // frame size from held format; fields move only inside fmt chunks and at end of file
  assign fprod     = 29'(bits_r[15:3]) * 29'(chan_r);
  assign fsize_nxt = (fprod != '0) ? 32'(fprod) : 32'(align_r);

  always_comb begin
    phase_nxt = phase_r;   pos_nxt = pos_r;       id_nxt = id_r;
    remain_nxt = remain_r; pad_nxt = pad_r;       fmt_nxt = fmt_r;
    chan_nxt = chan_r;     rate_nxt = rate_r;     align_nxt = align_r;
    bits_nxt = bits_r;     fbc_nxt = fbc_r;       first_nxt = first_r;
    second_nxt = second_r; frames_nxt = frames_r; len_nxt = len_r;
    job_nxt = '0;
    ssz = {3'b000, bits_r[15:3]};
    qs = fbc_r - 32'(ssz);
    raw1 = first_r;
    raw2 = second_r;
    if (acc) begin
      if (len_r < wavs_pkg::MIN_FILE_BYTES) len_nxt = len_r + 6'd1;
      case (phase_r)
        PH_HEADER: begin
          if (pos_r < 5'd4 && data_byte != wavs_pkg::RIFF_ID[{~pos_r[1:0], 3'b000} +: 8])
            phase_nxt = PH_BAD;
          else if (pos_r >= 5'd8 && pos_r < 5'd12 &&
                   data_byte != wavs_pkg::WAVE_ID[{~pos_r[1:0], 3'b000} +: 8])
            phase_nxt = PH_BAD;
          else if (pos_r == 5'd11) begin
            phase_nxt = PH_CHUNK_HEAD;
            pos_nxt = '0;
          end else pos_nxt = pos_r + 5'd1;
        end
        PH_CHUNK_HEAD: begin
          if (pos_r < 5'd4) id_nxt = {id_r[23:0], data_byte};
          else remain_nxt[{pos_r[1:0], 3'b000} +: 8] = data_byte;
          pos_nxt = pos_r + 5'd1;
          if (pos_r == 5'd7) begin
            pad_nxt = remain_nxt[0];
            pos_nxt = '0;
            if (id_r == wavs_pkg::FMT_ID && remain_nxt >= 32'd16) phase_nxt = PH_FMT;
            else if (id_r == wavs_pkg::DATA_ID && chan_r != '0 && rate_r != '0 &&
                     bits_r != '0 && fsize_r != '0) begin
              phase_nxt = PH_DATA;
              fbc_nxt = '0;
              first_nxt = '0;
              second_nxt = '0;
            end else phase_nxt = PH_SKIP;
            if (remain_nxt == '0) phase_nxt = remain_nxt[0] ? PH_PAD : PH_CHUNK_HEAD;
          end
        end
        PH_FMT, PH_DATA, PH_SKIP: begin
          if (phase_r == PH_FMT && pos_r < 5'd16) begin
            if (pos_r < 5'd2) fmt_nxt[{pos_r[0], 3'b000} +: 8] = data_byte;
            else if (pos_r < 5'd4) chan_nxt[{pos_r[0], 3'b000} +: 8] = data_byte;
            else if (pos_r < 5'd8) rate_nxt[{pos_r[1:0], 3'b000} +: 8] = data_byte;
            else if (pos_r >= 5'd12 && pos_r < 5'd14)
              align_nxt[{pos_r[0], 3'b000} +: 8] = data_byte;
            else if (pos_r >= 5'd14) bits_nxt[{pos_r[0], 3'b000} +: 8] = data_byte;
            pos_nxt = pos_r + 5'd1;
          end else if (phase_r == PH_DATA) begin
            if (fbc_r < 32'(ssz) && fbc_r < 32'd4)
              raw1 = first_r | (32'(data_byte) << {fbc_r[1:0], 3'b000});
            else if (fbc_r >= 32'(ssz) && qs < 32'(ssz) && qs < 32'd4)
              raw2 = second_r | (32'(data_byte) << {qs[1:0], 3'b000});
            if ({1'b0, fbc_r} + 33'd1 >= {1'b0, fsize_r}) begin
              if (frames_r != '1) frames_nxt = frames_r + 32'd1;
              job_nxt.frame_v = 1'b1;
              job_nxt.frame_last = !eof;
              job_nxt.raw_first = raw1;
              job_nxt.raw_second = raw2;
              fbc_nxt = '0;
              first_nxt = '0;
              second_nxt = '0;
            end else begin
              fbc_nxt = fbc_r + 32'd1;
              first_nxt = raw1;
              second_nxt = raw2;
            end
          end
          remain_nxt = remain_r - 32'd1;
          if (remain_nxt == '0) begin
            phase_nxt = pad_r ? PH_PAD : PH_CHUNK_HEAD;
            pos_nxt = '0;
          end
        end
        PH_PAD: begin
          phase_nxt = PH_CHUNK_HEAD;
          pos_nxt = '0;
        end
        default: ;
      endcase
      job_nxt.fmt_code = fmt_r;
      job_nxt.bits = bits_r;
      job_nxt.chan_one = (chan_nxt == 16'd1);
      job_nxt.rate = rate_nxt;
      job_nxt.total = frames_nxt;
      if (eof) begin
        job_nxt.final_v = 1'b1;
        if (phase_nxt == PH_BAD || phase_nxt == PH_HEADER ||
            len_nxt < wavs_pkg::MIN_FILE_BYTES)
          job_nxt.status = wavs_pkg::ST_BAD_HDR;
        else if (frames_nxt != '0 && chan_nxt != '0 && rate_nxt != '0 && bits_nxt != '0)
          job_nxt.status = wavs_pkg::ST_ACCEPTED;
        else
          job_nxt.status = wavs_pkg::ST_UNUSABLE;
        // file done: back to reset values for the next file
        phase_nxt = PH_HEADER;  pos_nxt = '0;        id_nxt = '0;
        remain_nxt = '0;        pad_nxt = 1'b0;      fmt_nxt = 16'd1;
        chan_nxt = 16'd2;       rate_nxt = 32'd44100; align_nxt = 16'd4;
        bits_nxt = 16'd16;      fbc_nxt = '0;        first_nxt = '0;
        second_nxt = '0;        frames_nxt = '0;     len_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;  pos_r <= '0;          id_r <= '0;
      remain_r <= '0;        pad_r <= 1'b0;        fmt_r <= 16'd1;
      chan_r <= 16'd2;       rate_r <= 32'd44100;  align_r <= 16'd4;
      bits_r <= 16'd16;      fbc_r <= '0;          first_r <= '0;
      second_r <= '0;        frames_r <= '0;       len_r <= '0;
      fsize_r <= 32'd4;      job_r <= '0;
    end else begin
      phase_r <= phase_nxt;   pos_r <= pos_nxt;       id_r <= id_nxt;
      remain_r <= remain_nxt; pad_r <= pad_nxt;       fmt_r <= fmt_nxt;
      chan_r <= chan_nxt;     rate_r <= rate_nxt;     align_r <= align_nxt;
      bits_r <= bits_nxt;     fbc_r <= fbc_nxt;       first_r <= first_nxt;
      second_r <= second_nxt; frames_r <= frames_nxt; len_r <= len_nxt;
      fsize_r <= fsize_nxt;   job_r <= job_nxt;
    end
  end

endmodule

FILE: design/wavs_convert.sv
// Sample conversion: raw sample bytes to clamped PCM16 and Q1.23 mono.
// Depends on wavs_pkg.
module wavs_convert (
  input  wavs_pkg::wavs_job_t  job,
  output wavs_pkg::wavs_push_t push
);

  // IEEE single to Q1.31 (33-bit signed), truncating toward zero
  function automatic logic signed [32:0] float_q31(input logic [31:0] raw);
    logic [7:0]  e;
    logic [22:0] f;
    logic [31:0] m;
    logic [32:0] mag;
    logic [7:0]  rsh;
    logic [7:0]  lsh;
    e = raw[30:23];
    f = raw[22:0];
    m = {8'd0, 1'b1, f};
    rsh = 8'd119 - e;
    lsh = e - 8'd119;
    if (e == 8'hFF && f != '0) mag = '0;
    else if (e >= 8'd127) mag = 33'h0_8000_0000;
    else if (e == 8'd0) mag = '0;
    else if (e >= 8'd119) mag = 33'(m << lsh[2:0]);
    else if (rsh >= 8'd32) mag = '0;
    else mag = 33'(m >> rsh[4:0]);
    return raw[31] ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [32:0] sample_q31(input logic [15:0] fc,
                                                    input logic [15:0] bits,
                                                    input logic [31:0] raw);
    logic signed [32:0] v;
    v = '0;
    if (fc == wavs_pkg::FMT_FLOAT) begin
      if (bits == 16'd32) v = float_q31(raw);
    end else begin
      case (bits)
        16'd8:  v = $signed({~raw[7], ~raw[7], raw[6:0], 24'd0});
        16'd16: v = $signed({raw[15], raw[15:0], 16'd0});
        16'd24: v = $signed({raw[23], raw[23:0], 8'd0});
        16'd32: v = $signed({raw[31], raw[31:0]});
        default: v = '0;
      endcase
    end
    return v;
  endfunction

  // trunc(v * 32767 / 2^31) in sign-magnitude
  function automatic logic signed [15:0] to_pcm(input logic signed [32:0] v);
    logic [31:0] mag;
    logic [46:0] prod;
    logic [15:0] p;
    mag = v[32] ? 32'(-v) : v[31:0];
    prod = 47'(mag) * 47'd32767;
    p = prod[46:31];
    return v[32] ? -$signed(p) : $signed(p);
  endfunction

  logic signed [32:0] v1, v2;
  logic signed [33:0] vsum;
  logic [32:0]        smag;
  logic [23:0]        mmag;
  logic               mneg;
  logic signed [24:0] mono;
  logic signed [23:0] mono_sat;
  logic [1:0]         chans;

  assign v1   = sample_q31(job.fmt_code, job.bits, job.raw_first);
  assign v2   = job.chan_one ? '0 : sample_q31(job.fmt_code, job.bits, job.raw_second);
  assign vsum = 34'(v1) + 34'(v2);
  assign smag = vsum[33] ? 33'(-vsum) : vsum[32:0];
  assign mmag = job.chan_one ? 24'(smag >> 8) : 24'(smag >> 9);
  assign mneg = vsum[33];
  assign mono = mneg ? -$signed({1'b0, mmag}) : $signed({1'b0, mmag});
  assign mono_sat = (mono > 25'sd8388607) ? 24'sd8388607 : mono[23:0];
  assign chans = job.chan_one ? 2'd1 : 2'd2;

  always_comb begin
    push.frame_v = job.frame_v;
    push.final_v = job.final_v;
    push.frame_res.status       = wavs_pkg::ST_FRAME;
    push.frame_res.pcm_first    = to_pcm(v1);
    push.frame_res.pcm_second   = to_pcm(v2);
    push.frame_res.mono_level   = mono_sat;
    push.frame_res.channels_out = chans;
    push.frame_res.rate_hz      = job.rate;
    push.frame_res.frame_total  = job.total;
    push.frame_res.result_last  = job.frame_last;
    push.final_res.status       = job.status;
    push.final_res.pcm_first    = '0;
    push.final_res.pcm_second   = '0;
    push.final_res.mono_level   = '0;
    push.final_res.channels_out = chans;
    push.final_res.rate_hz      = job.rate;
    push.final_res.frame_total  = job.total;
    push.final_res.result_last  = 1'b1;
  end

endmodule

FILE: design/wavs_result_queue.sv
// Four-entry result queue: takes up to two results a cycle, gives one.
// Depends on wavs_pkg.
module wavs_result_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  wavs_pkg::wavs_push_t  push,
  input  logic                  pop,
  output wavs_pkg::wavs_result_t head,
  output wavs_pkg::wavs_qstat_t stat
);

  wavs_pkg::wavs_result_t mem [wavs_pkg::QDEPTH];
  logic [1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [1:0] npush;

  assign npush  = 2'(push.frame_v) + 2'(push.final_v);
  assign wr_nxt = wr_r + npush;
  assign rd_nxt = rd_r + 2'(pop);
  assign cnt_nxt = cnt_r + 3'(npush) - 3'(pop);
  assign head = mem[rd_r];
  assign stat.count = cnt_r;
  assign stat.empty = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (push.frame_v) mem[wr_r] <= push.frame_res;
    if (push.final_v) begin
      if (push.frame_v) mem[wr_r + 2'd1] <= push.final_res;
      else mem[wr_r] <= push.final_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_r <= wr_nxt;
      rd_r <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: design/wav_stream_to_pcm16_unit.sv
// WAV byte stream to PCM16 decoder, top level.
// A byte that closes a frame and the file gives two results, queued four deep.
// Throughput: one byte per cycle while in_ch.ready is high, which it is only while
// two or fewer results are owed; results drain one per cycle while out_ch is ready.
// Reset: synchronous active-low rst_n returns parser, queue and pipeline to idle.
// Depends on wavs_pkg, wavs_if, wavs_parser, wavs_convert, wavs_result_queue.
module wav_stream_to_pcm16_unit (
  input  logic            clk,
  input  logic            rst_n,
  wavs_in_if.sink         in_ch,
  wavs_out_if.source      out_ch
);

  wavs_pkg::wavs_job_t    job;
  wavs_pkg::wavs_push_t   push;
  wavs_pkg::wavs_result_t head;
  wavs_pkg::wavs_qstat_t  qstat;
  logic                   in_acc;
  logic                   out_acc;
  logic [3:0]             pending;

  // results still owed: queued plus those in the job register
  assign pending = 4'(qstat.count) + 4'(job.frame_v) + 4'(job.final_v);
  // leave room for the two results a new byte can produce
  assign in_ch.ready = (pending <= 4'd2);
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  wavs_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (in_acc),
    .data_byte (in_ch.data_byte),
    .eof       (in_ch.end_of_file),
    .job_r     (job)
  );

  wavs_convert u_convert (
    .job  (job),
    .push (push)
  );

  wavs_result_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (out_acc),
    .head  (head),
    .stat  (qstat)
  );

  assign out_ch.valid        = !qstat.empty;
  assign out_ch.status       = head.status;
  assign out_ch.pcm_first    = head.pcm_first;
  assign out_ch.pcm_second   = head.pcm_second;
  assign out_ch.mono_level   = head.mono_level;
  assign out_ch.channels_out = head.channels_out;
  assign out_ch.rate_hz      = head.rate_hz;
  assign out_ch.frame_total  = head.frame_total;
  assign out_ch.result_last  = head.result_last;

  // queue never overfills
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.count <= 3'd4) else $error("result queue overflow");

  // only frame results may be followed by more results of the same byte
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.result_last |-> out_ch.status == wavs_pkg::ST_FRAME)
    else $error("non-frame result without result_last");

  // end-of-file byte always yields a final result job
  a_eof_final: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.end_of_file |=> job.final_v)
    else $error("end of file without final result");

endmodule

FILE: dv/tb.sv
// Self-checking testbench for wav_stream_to_pcm16_unit: WAV bytes in, frame/final results out.
// Depends on wavs_pkg, wavs_if and the unit's RTL; predicts every result on its own.
`timescale 1ns / 100ps

module tb;

  // Parser phases of the decoder as the predictor tracks them
  typedef enum bit [2:0] {
    P_HDR, P_HEAD, P_FMT, P_DATA, P_SKIP, P_PAD, P_BAD
  } phase_t;

  localparam bit [15:0] FMT_PCM = 16'd1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  wavs_in_if  in_ch ();
  wavs_out_if out_ch ();

  wav_stream_to_pcm16_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Decoder state mirror
  // ---------------------------------------------------------------------------
  phase_t     phase;
  bit [4:0]   pos;
  bit [31:0]  head_id, chunk_left;
  bit         pad_due;
  bit [15:0]  fmt_code, chans, align, bits;
  bit [31:0]  rate, frame_pos, word_a, word_b, nframes;
  int         bytes_seen;

  wavs_pkg::wavs_result_t pending_results[$];  // results still owed by the DUT
  int           mismatches = 0;
  bit [7:0]     file_q[$];           // bytes of the file being built
  int           bytes_sent = 0;      // accepted input transactions

  // Receiver-side hold-off request, serviced by the ready process
  bit hold_req = 1'b0;
  int hold_left = 0;

  task automatic clear_decoder();
    phase = P_HDR; pos = '0; head_id = '0; chunk_left = '0; pad_due = 1'b0;
    fmt_code = FMT_PCM; chans = 16'd2; rate = 32'd44100; align = 16'd4; bits = 16'd16;
    frame_pos = '0; word_a = '0; word_b = '0; nframes = '0; bytes_seen = 0;
  endtask

  function automatic bit [31:0] frame_bytes();
    bit [31:0] fb;
    fb = 32'(bits >> 3) * 32'(chans);
    return (fb != 0) ? fb : 32'(align);
  endfunction

  // IEEE single to Q1.31, truncating toward zero; NaN reads as zero
  function automatic longint float_q31(bit [31:0] raw);
    int unsigned e;
    longint mag;
    int sh;
    e = raw[30:23];
    if (e == 255 && raw[22:0] != 0) return 0;
    if (e >= 127) mag = longint'(1) << 31;
    else if (e == 0) mag = 0;
    else begin
      sh = int'(e) - 119;
      if (sh >= 0) mag = longint'({1'b1, raw[22:0]}) << sh;
      else if (-sh >= 32) mag = 0;
      else mag = longint'({1'b1, raw[22:0]}) >> (-sh);
    end
    return raw[31] ? -mag : mag;
  endfunction

  function automatic longint sample_q31(bit [31:0] raw);
    if (fmt_code == wavs_pkg::FMT_FLOAT) return (bits == 16'd32) ? float_q31(raw) : 0;
    case (bits)
      16'd8:  return (longint'(raw[7:0]) - 128) * 16777216;
      16'd16: return longint'(signed'(raw[15:0])) * 65536;
      16'd24: return longint'(signed'(raw[23:0])) * 256;
      16'd32: return longint'(signed'(raw));
      default: return 0;
    endcase
  endfunction

  // sign-magnitude multiply then right shift, i.e. truncation toward zero
  function automatic longint trunc_mul(longint v, longint mul, int sh);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = (mag * mul) >>> sh;
    return (v < 0) ? -mag : mag;
  endfunction

  function automatic wavs_pkg::wavs_result_t make_result(bit [1:0] st, longint a, longint b,
                                                         longint m, bit last);
    wavs_pkg::wavs_result_t r;
    r.status       = st;
    r.pcm_first    = a[15:0];
    r.pcm_second   = b[15:0];
    r.mono_level   = m[23:0];
    r.channels_out = (chans == 16'd1) ? 2'd1 : 2'd2;
    r.rate_hz      = rate;
    r.frame_total  = nframes;
    r.result_last  = last;
    return r;
  endfunction

  task automatic close_chunk();
    phase = pad_due ? P_PAD : P_HEAD;
    pos = '0;
  endtask

  // Advance the mirror by one accepted byte and queue what it must produce
  task automatic decode_byte(bit [7:0] b, bit eof);
    int unsigned p;
    bit [31:0] s, q;
    longint v1, v2, mono;
    bit [1:0] st;
    p = pos;
    if (bytes_seen < wavs_pkg::MIN_FILE_BYTES) bytes_seen++;
    case (phase)
      P_HDR: begin
        if (p < 4 && b != wavs_pkg::RIFF_ID[31 - 8*p -: 8]) phase = P_BAD;
        else if (p >= 8 && p < 12 && b != wavs_pkg::WAVE_ID[31 - 8*(p-8) -: 8]) phase = P_BAD;
        else if (p == 11) begin
          phase = P_HEAD; pos = '0;
        end else pos = 5'(p + 1);
      end
      P_HEAD: begin
        if (p < 4) head_id = {head_id[23:0], b};
        else chunk_left[8*(p-4) +: 8] = b;
        pos = 5'(p + 1);
        if (p == 7) begin
          pad_due = chunk_left[0];
          pos = '0;
          if (head_id == wavs_pkg::FMT_ID && chunk_left >= 16) phase = P_FMT;
          else if (head_id == wavs_pkg::DATA_ID && chans != 0 && rate != 0 && bits != 0 &&
                   frame_bytes() != 0) begin
            phase = P_DATA; frame_pos = '0; word_a = '0; word_b = '0;
          end else phase = P_SKIP;
          if (chunk_left == 0) close_chunk();
        end
      end
      P_FMT, P_DATA, P_SKIP: begin
        if (phase == P_FMT && p < 16) begin
          if (p < 2) fmt_code[8*p +: 8] = b;
          else if (p < 4) chans[8*(p-2) +: 8] = b;
          else if (p < 8) rate[8*(p-4) +: 8] = b;
          else if (p >= 12 && p < 14) align[8*(p-12) +: 8] = b;
          else if (p >= 14) bits[8*(p-14) +: 8] = b;
          pos = 5'(p + 1);
        end else if (phase == P_DATA) begin
          q = frame_pos;
          s = 32'(bits >> 3);
          if (q < s && q < 4) word_a[8*q +: 8] = b;
          else if (q >= s && q - s < s && q - s < 4) word_b[8*(q-s) +: 8] = b;
          if (q + 1 >= frame_bytes()) begin
            v1 = sample_q31(word_a);
            v2 = (chans == 16'd1) ? 0 : sample_q31(word_b);
            if (chans == 16'd1) mono = trunc_mul(v1, 1, 8);
            else mono = trunc_mul(v1 + v2, 1, 9);
            if (mono > 8388607) mono = 8388607;
            if (nframes != 32'hFFFF_FFFF) nframes++;
            pending_results.push_back(make_result(wavs_pkg::ST_FRAME,
                                                  trunc_mul(v1, 32767, 31),
                                                  trunc_mul(v2, 32767, 31), mono, !eof));
            frame_pos = '0; word_a = '0; word_b = '0;
          end else frame_pos = q + 1;
        end
        chunk_left--;
        if (chunk_left == 0) close_chunk();
      end
      P_PAD: begin
        phase = P_HEAD; pos = '0;
      end
      default: ;
    endcase
    if (eof) begin
      if (phase == P_BAD || phase == P_HDR || bytes_seen < wavs_pkg::MIN_FILE_BYTES)
        st = wavs_pkg::ST_BAD_HDR;
      else if (nframes != 0 && chans != 0 && rate != 0 && bits != 0)
        st = wavs_pkg::ST_ACCEPTED;
      else st = wavs_pkg::ST_UNUSABLE;
      pending_results.push_back(make_result(st, 0, 0, 0, 1'b1));
      clear_decoder();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender: one byte per call, called at a falling edge, returns at one.
  // valid stays high across back-to-back bytes and only drops for a gap.
  // ---------------------------------------------------------------------------
  int idle_free = 0;  // while nonzero, sender inserts no gaps

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_byte(bit [7:0] b, bit eof);
    int g;
    g = (idle_free > 0) ? 0 : gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.data_byte   <= b;
    in_ch.end_of_file <= eof;
    do @(posedge clk); while (!in_ch.ready);
    decode_byte(b, eof);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_file();
    foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1);
    file_q.delete();
  endtask

  task automatic idle_input();
    in_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // File builders (little-endian fields)
  // ---------------------------------------------------------------------------
  task automatic put32(bit [31:0] v);
    for (int i = 0; i < 4; i++) file_q.push_back(v[8*i +: 8]);
  endtask

  task automatic put_header();
    put32({<<8{wavs_pkg::RIFF_ID}});
    put32($urandom);
    put32({<<8{wavs_pkg::WAVE_ID}});
  endtask

  task automatic put_fmt(bit [31:0] size, bit [15:0] code, bit [15:0] ch, bit [31:0] sr,
                         bit [15:0] al, bit [15:0] bw);
    put32({<<8{wavs_pkg::FMT_ID}});
    put32(size);
    file_q.push_back(code[7:0]); file_q.push_back(code[15:8]);
    file_q.push_back(ch[7:0]);   file_q.push_back(ch[15:8]);
    put32(sr);
    put32($urandom);
    file_q.push_back(al[7:0]);   file_q.push_back(al[15:8]);
    file_q.push_back(bw[7:0]);   file_q.push_back(bw[15:8]);
    for (int i = 16; i < size; i++) file_q.push_back($urandom);
    if (size[0]) file_q.push_back($urandom);
  endtask

  // Data chunk of random bytes; float-looking words mixed in near +-1.0
  task automatic put_data(int nbytes, bit floats);
    bit [31:0] w;
    put32({<<8{wavs_pkg::DATA_ID}});
    put32(nbytes);
    for (int i = 0; i < nbytes; i++) begin
      if (floats && i % 4 == 0 && i + 4 <= nbytes && $urandom_range(0, 1)) begin
        w = {1'($urandom), 8'($urandom_range(110, 130)), 23'($urandom)};
        if ($urandom_range(0, 7) == 0) w[30:23] = 8'hFF;  // inf / NaN
        put32(w);
        i += 3;
      end else file_q.push_back($urandom);
    end
    if (nbytes % 2) file_q.push_back($urandom);
  endtask

  task automatic put_chunk(bit [31:0] id, int nbytes);
    put32({<<8{id}});
    put32(nbytes);
    repeat (nbytes + nbytes % 2) file_q.push_back($urandom);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random ready, long hold-offs on request, no-stall stretches
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      out_ch.ready <= 1'b0;
      hold_left <= 300;
      hold_req <= 1'b0;
    end else if (idle_free > 0) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) < 70);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    wavs_pkg::wavs_result_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.status       = out_ch.status;
      got.pcm_first    = out_ch.pcm_first;
      got.pcm_second   = out_ch.pcm_second;
      got.mono_level   = out_ch.mono_level;
      got.channels_out = out_ch.channels_out;
      got.rate_hz      = out_ch.rate_hz;
      got.frame_total  = out_ch.frame_total;
      got.result_last  = out_ch.result_last;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected transaction st=%0d", $realtime, got.status);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.pcm_first !== want.pcm_first ||
            got.pcm_second !== want.pcm_second || got.mono_level !== want.mono_level ||
            got.channels_out !== want.channels_out ||
            got.rate_hz !== want.rate_hz ||
            got.frame_total !== want.frame_total ||
            got.result_last !== want.result_last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch exp st=%0d a=%0d b=%0d m=%0d ch=%0d sr=%0d n=%0d l=%0d\n",
                     $realtime, want.status, want.pcm_first, want.pcm_second,
                     want.mono_level, want.channels_out, want.rate_hz,
                     want.frame_total, want.result_last,
                     "               got st=%0d a=%0d b=%0d m=%0d ch=%0d sr=%0d n=%0d l=%0d",
                     got.status, got.pcm_first, got.pcm_second, got.mono_level,
                     got.channels_out, got.rate_hz, got.frame_total, got.result_last);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // every sample width and format, mono/stereo/multichannel, align fallback
  task automatic test_formats();
    put_header(); put_fmt(16, FMT_PCM, 1, 8000, 1, 8); put_data(3, 0); send_file();
    put_header(); put_fmt(16, FMT_PCM, 2, 44100, 4, 16); put_data(8, 0); send_file();
    put_header(); put_fmt(18, FMT_PCM, 3, 48000, 9, 24); put_data(9, 0); send_file();
    put_header(); put_fmt(16, FMT_PCM, 2, 96000, 8, 32); put_data(8, 0); send_file();
    put_header(); put_fmt(16, wavs_pkg::FMT_FLOAT, 2, 32'hFFFF_FFFF, 8, 32); put_data(24, 1);
    send_file();
    // float code with a non-32 width, and odd width with align used as frame size
    put_header(); put_fmt(16, wavs_pkg::FMT_FLOAT, 1, 1, 2, 16); put_data(4, 0); send_file();
    put_header(); put_fmt(16, FMT_PCM, 1, 1, 3, 4); put_data(7, 0); send_file();
    // defaults: no fmt chunk before data
    put_header(); put_chunk(32'h4C495354, 5); put_data(12, 0); send_file();
  endtask

  // hand-picked float words: NaN, -inf, +1, -0.5, denormal, tiny, +-just below 1
  task automatic test_float_edges();
    bit [31:0] words[8] = '{32'h7FC0_0000, 32'hFF80_0000, 32'h3F80_0000, 32'hBF00_0000,
                            32'h0000_0001, 32'h3380_0000, 32'h3F7F_FFFF, 32'hBF7F_FFFF};
    put_header(); put_fmt(16, wavs_pkg::FMT_FLOAT, 2, 22050, 8, 32);
    put32({<<8{wavs_pkg::DATA_ID}}); put32(32);
    foreach (words[i]) put32(words[i]);
    send_file();
    // integer extremes at 16 bits
    put_header(); put_fmt(16, FMT_PCM, 2, 44100, 4, 16);
    put32({<<8{wavs_pkg::DATA_ID}}); put32(12);
    put32(32'h7FFF_7FFF); put32(32'h8000_8000); put32(32'h8000_7FFF);
    send_file();
  endtask

  // header and length faults, unusable formats, short fmt, truncation
  task automatic test_faults();
    put_header(); file_q[2] = 8'h00; put_fmt(16, FMT_PCM, 1, 8000, 1, 8);
    put_data(4, 0); send_file();
    put_header(); file_q[10] = 8'h00; put_fmt(16, FMT_PCM, 1, 8000, 1, 8);
    put_data(4, 0); send_file();
    put_header(); file_q = file_q[0:5]; send_file();           // ends inside header
    put_header(); put_chunk(32'h6A756E6B, 4); put_data(6, 0); send_file();  // < 44 bytes
    put_header(); put_fmt(16, FMT_PCM, 0, 8000, 2, 16); put_data(8, 0); send_file();
    put_header(); put_fmt(16, FMT_PCM, 2, 0, 4, 16); put_data(8, 0); send_file();
    put_header(); put_fmt(16, FMT_PCM, 2, 8000, 0, 0); put_data(8, 0); send_file();
    put_header(); put_fmt(16, FMT_PCM, 2, 8000, 0, 4); put_data(8, 0); send_file();
    // short fmt declared 12 bytes is skipped, defaults remain
    put_header(); put_chunk(wavs_pkg::FMT_ID, 12); put_data(12, 0); send_file();
    // empty data chunk, then fmt cut short by end of file
    put_header(); put_fmt(16, FMT_PCM, 1, 8000, 1, 8); put_data(0, 0);
    put_data(5, 0); put_fmt(16, FMT_PCM, 2, 1, 4, 16); file_q = file_q[0:$-9];
    send_file();
    // data chunk cut inside a frame
    put_header(); put_fmt(16, FMT_PCM, 2, 8000, 8, 32); put_data(40, 0);
    file_q = file_q[0:$-3]; send_file();
  endtask

  // random files, mostly well formed, some broken or truncated
  task automatic random_file();
    bit [15:0] code, ch, bw, al;
    int nchunks, fs;
    code = ($urandom_range(0, 9) < 6) ? FMT_PCM :
           ($urandom_range(0, 3) ? wavs_pkg::FMT_FLOAT : 16'($urandom));
    ch = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom_range(1, 4));
    case ($urandom_range(0, 7))
      0: bw = 16'd8;  1, 2: bw = 16'd16;  3: bw = 16'd24;  4, 5: bw = 16'd32;
      6: bw = 16'($urandom_range(0, 7));  default: bw = 16'($urandom);
    endcase
    if (bw > 16'd64) bw = {$urandom_range(0, 1) ? 8'h00 : 8'h80, bw[7:0]};
    al = 16'($urandom_range(0, 12));
    if ($urandom_range(0, 9) == 0) al[15] = 1'b1;
    fs = (bw >> 3) * ch;
    if (fs == 0) fs = al;
    if (fs > 64) fs = 4;
    put_header();
    if ($urandom_range(0, 15) == 0) file_q[$urandom_range(0, 11)] ^= 8'($urandom_range(1, 255));
    if ($urandom_range(0, 7) != 0)
      put_fmt($urandom_range(0, 5) ? 16 : $urandom_range(10, 21), code, ch,
              $urandom_range(0, 30) ? $urandom : 0, al, bw);
    nchunks = $urandom_range(1, 3);
    for (int c = 0; c < nchunks; c++) begin
      case ($urandom_range(0, 5))
        0: put_chunk($urandom, $urandom_range(0, 7));
        1: put_fmt(16, code, ch, $urandom, al, bw);
        default: put_data(fs * $urandom_range(0, 8) + ($urandom_range(0, 3) == 0),
                          code == wavs_pkg::FMT_FLOAT);
      endcase
    end
    if ($urandom_range(0, 7) == 0 && file_q.size() > 2)
      file_q = file_q[0:$urandom_range(0, file_q.size() - 1)];
    if ($urandom_range(0, 31) == 0) repeat ($urandom_range(1, 40)) file_q.push_back($urandom);
    send_file();
  endtask

  // random files until the whole run has sent about 1500 bytes
  task automatic test_random_files();
    while (bytes_sent < 1500) begin
      random_file();
      if ($urandom_range(0, 15) == 0) idle_free = $urandom_range(50, 200);
    end
  endtask

  // receiver holds off for a long stretch while bytes keep coming
  task automatic test_backpressure();
    hold_req = 1'b1;
    put_header(); put_fmt(16, FMT_PCM, 1, 8000, 1, 8); put_data(30, 0); send_file();
  endtask

  // sender stops until the output has fully drained, then resumes
  task automatic test_pause_drain();
    put_header(); put_fmt(16, FMT_PCM, 2, 8000, 4, 16); put_data(16, 0);
    file_q = file_q[0:$-1];
    foreach (file_q[i]) send_byte(file_q[i], 1'b0);
    file_q.delete();
    idle_input();
    wait_drained();
    send_byte($urandom, 1'b1);
  endtask

  // count down the no-stall window once per cycle
  always @(negedge clk) if (idle_free > 0) idle_free <= idle_free - 1;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.end_of_file = 1'b0;
    out_ch.ready = 1'b0;
    clear_decoder();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_formats();
    test_float_edges();
    test_faults();
    test_backpressure();
    test_pause_drain();
    test_random_files();
    test_backpressure();

    idle_input();
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
